// ----- sv/ptd_pkg.sv -----
`default_nettype none
package ptd_pkg;

  localparam int TICK_W          = 16;
  localparam int OP_W            = 3;
  localparam int SLOT_W          = 3;
  localparam int DEF_TASK_SLOTS  = 8;
  localparam int ADDR_SLOTS      = 1 << SLOT_W;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUSPEND = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_TAKEN = 1'b1;

endpackage
`default_nettype wire

// ----- sv/ptd_rem.sv -----
`default_nettype none
module ptd_rem #(
  parameter int W = ptd_pkg::TICK_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W:0]       rem_q;
  logic [W-1:0]     dvd;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted   = {rem_q[W-1:0], dvd[W-1]};
  assign diff      = shifted - {1'b0, dvs};
  assign remainder = rem_q[W-1:0];

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNT_W'(W);
        rem_q <= '0;
        dvd   <= dividend;
        dvs   <= divisor;
      end else if (run) begin
        rem_q <= diff[W] ? shifted : diff;
        dvd   <= {dvd[W-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/periodic_task_dispatcher_unit.sv -----
`default_nettype none
// Channel  Handshake           Payload
// in       in_valid/in_ready   operation, slot, period
// out      out_valid/out_ready kind, status, task_due, task_res, last
//
// Create, delete, suspend and resume are handled in the idle state. A tick
// scans each slot, reads the period of each present and resumed slot, and where
// that period is non-zero runs a bit-serial remainder of the tick count by it.
// Results then go out in slot order up to the last due one; the walk waits on
// each due slot until the out channel is free. Reset clears the counter and all
// flags; periods are undefined until created. A stalled out channel holds the
// result phase; no item is taken during a tick or while a result waits.
module periodic_task_dispatcher_unit #(
  parameter int TASK_SLOTS = ptd_pkg::DEF_TASK_SLOTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ptd_pkg::OP_W-1:0]    operation,
  input  wire logic [ptd_pkg::SLOT_W-1:0]  slot,
  input  wire logic [ptd_pkg::TICK_W-1:0]  period,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             kind,
  output logic                             status,
  output logic                             task_due,
  output logic [ptd_pkg::SLOT_W-1:0]       task_res,
  output logic                             last
);

  localparam int TW     = ptd_pkg::TICK_W;
  localparam int SCAN   = (TASK_SLOTS < ptd_pkg::ADDR_SLOTS) ? TASK_SLOTS
                                                            : ptd_pkg::ADDR_SLOTS;
  localparam int ADDR_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int IDX_W  = (SCAN > 1) ? $clog2(SCAN) : 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t            state;
  logic [TW-1:0]     tick_count;
  logic [TASK_SLOTS-1:0] present;
  logic [TASK_SLOTS-1:0] resumed;
  logic [IDX_W-1:0]  scan_idx;
  logic [SCAN-1:0]   due_vec;
  logic [SCAN-1:0]   due_rest;

  logic [TW-1:0]     mem [TASK_SLOTS];
  logic [TW-1:0]     rd_data;

  logic              in_fire;
  logic              out_free;
  logic              out_load;
  logic              in_table;
  logic [ADDR_W-1:0] slot_a;
  logic [ADDR_W-1:0] scan_a;
  logic              create_ok;
  logic              mem_we;
  logic              scan_end;
  logic              rem_start;
  logic              rem_done;
  logic [TW-1:0]     rem_val;

  assign in_ready  = (state == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (in_fire && (operation == ptd_pkg::OP_CREATE)) ||
                     ((state == S_EMIT) && out_free &&
                      ((due_vec == '0) || due_vec[scan_idx]));
  assign in_table  = 32'(slot) < TASK_SLOTS;
  assign slot_a    = ADDR_W'(slot);
  assign scan_a    = ADDR_W'(scan_idx);
  assign create_ok = in_table && !present[slot_a];
  assign mem_we    = in_fire && (operation == ptd_pkg::OP_CREATE) && create_ok;
  assign scan_end  = (32'(scan_idx) == SCAN - 1);
  assign rem_start = (state == S_START) && (rd_data != '0);

  always_comb begin
    due_rest           = due_vec;
    due_rest[scan_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_a] <= period;
    end
    rd_data <= mem[scan_a];
  end

  ptd_rem #(.W(TW)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (tick_count),
    .divisor   (rd_data),
    .done      (rem_done),
    .remainder (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      present    <= '0;
      resumed    <= '0;
      out_valid  <= 1'b0;
      scan_idx   <= '0;
      due_vec    <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (operation)
              ptd_pkg::OP_TICK: begin
                tick_count <= tick_count + TW'(1);
                scan_idx   <= '0;
                due_vec    <= '0;
                state      <= S_SCAN;
              end
              ptd_pkg::OP_CREATE: begin
                if (create_ok) begin
                  present[slot_a] <= 1'b1;
                  resumed[slot_a] <= 1'b1;
                end
                kind      <= ptd_pkg::KIND_CREATE;
                status    <= create_ok ? ptd_pkg::ST_OK : ptd_pkg::ST_TAKEN;
                task_due  <= 1'b0;
                task_res  <= slot;
                last      <= 1'b1;
              end
              ptd_pkg::OP_DELETE: begin
                if (in_table) present[slot_a] <= 1'b0;
              end
              ptd_pkg::OP_SUSPEND: begin
                if (in_table) resumed[slot_a] <= 1'b0;
              end
              ptd_pkg::OP_RESUME: begin
                if (in_table) resumed[slot_a] <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (present[scan_a] && resumed[scan_a]) begin
            state <= S_START;
          end else if (scan_end) begin
            scan_idx <= '0;
            state    <= S_EMIT;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_START: begin
          if (rd_data != '0) begin
            state <= S_DIV;
          end else if (scan_end) begin
            scan_idx <= '0;
            state    <= S_EMIT;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
            state    <= S_SCAN;
          end
        end
        S_DIV: begin
          if (rem_done) begin
            due_vec[scan_idx] <= (rem_val == '0);
            if (scan_end) begin
              scan_idx <= '0;
              state    <= S_EMIT;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
              state    <= S_SCAN;
            end
          end
        end
        S_EMIT: begin
          if (due_vec == '0) begin
            // nothing due on this tick
            if (out_free) begin
              kind      <= ptd_pkg::KIND_TICK;
              status    <= ptd_pkg::ST_OK;
              task_due  <= 1'b0;
              task_res  <= '0;
              last      <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (!due_vec[scan_idx]) begin
            scan_idx <= scan_idx + IDX_W'(1);
          end else if (out_free) begin
            kind      <= ptd_pkg::KIND_TICK;
            status    <= ptd_pkg::ST_OK;
            task_due  <= 1'b1;
            task_res  <= ptd_pkg::SLOT_W'(scan_idx);
            last      <= (due_rest == '0);
            due_vec   <= due_rest;
            if (due_rest == '0) begin
              state <= S_IDLE;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS          = ptd_pkg::DEF_TASK_SLOTS;
  localparam int HOLD_CYCLES    = 700;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 295;

  localparam logic [ptd_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [ptd_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic                       kind;
    logic                       status;
    logic                       task_due;
    logic [ptd_pkg::SLOT_W-1:0] task_res;
    logic                       last;
  } dispatch_t;

  class dispatch_scoreboard;
    bit [ptd_pkg::TICK_W-1:0] tick_count;
    bit [ptd_pkg::TICK_W-1:0] periods [SLOTS];
    bit              present [SLOTS];
    bit              resumed [SLOTS];
    dispatch_t       due_q[$];
    int              n_mismatch;
    int              n_results;
    int              n_ticks;
    int              n_idle_ticks;
    int              n_full_ticks;
    int              n_creates;
    int              n_refused;

    function int pending();
      return due_q.size();
    endfunction

    // Works out what one accepted item must produce and queues it.
    function void note_input(logic [ptd_pkg::OP_W-1:0] op,
                             logic [ptd_pkg::SLOT_W-1:0] s,
                             logic [ptd_pkg::TICK_W-1:0] p);
      bit [SLOTS-1:0] due_mask;
      int             hi;
      int             n;
      dispatch_t      r;
      bit             in_table;
      in_table = (int'(s) < SLOTS);
      case (op)
        ptd_pkg::OP_TICK: begin
          tick_count++;
          n_ticks++;
          due_mask = '0;
          hi = -1;
          n = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (present[i] && resumed[i] && periods[i] != 0 &&
                (tick_count % periods[i]) == 0) begin
              due_mask[i] = 1'b1;
              hi = i;
              n++;
            end
          end
          if (hi < 0) begin
            r = '{ptd_pkg::KIND_TICK, ptd_pkg::ST_OK, 1'b0, '0, 1'b1};
            due_q.push_back(r);
            n_idle_ticks++;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (due_mask[i]) begin
                r = '{ptd_pkg::KIND_TICK, ptd_pkg::ST_OK, 1'b1,
                      ptd_pkg::SLOT_W'(i), (i == hi)};
                due_q.push_back(r);
              end
            end
            if (n == SLOTS) n_full_ticks++;
          end
        end
        ptd_pkg::OP_CREATE: begin
          n_creates++;
          if (!in_table || present[s]) begin
            r = '{ptd_pkg::KIND_CREATE, ptd_pkg::ST_TAKEN, 1'b0, s, 1'b1};
            n_refused++;
          end else begin
            periods[s] = p;
            present[s] = 1'b1;
            resumed[s] = 1'b1;
            r = '{ptd_pkg::KIND_CREATE, ptd_pkg::ST_OK, 1'b0, s, 1'b1};
          end
          due_q.push_back(r);
        end
        ptd_pkg::OP_DELETE:  if (in_table) present[s] = 1'b0;
        ptd_pkg::OP_SUSPEND: if (in_table) resumed[s] = 1'b0;
        ptd_pkg::OP_RESUME:  if (in_table) resumed[s] = 1'b1;
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [ptd_pkg::SLOT_W-1:0] exp_v,
                                logic [ptd_pkg::SLOT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        n_mismatch++;
        $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(dispatch_t act);
      dispatch_t exp_r;
      n_results++;
      if (due_q.size() == 0) begin
        n_mismatch++;
        $display("%0t: result with none expected: expected nothing, got %p",
                 $time, act);
        return;
      end
      exp_r = due_q.pop_front();
      compare_field("kind", ptd_pkg::SLOT_W'(exp_r.kind),
                    ptd_pkg::SLOT_W'(act.kind));
      compare_field("status", ptd_pkg::SLOT_W'(exp_r.status),
                    ptd_pkg::SLOT_W'(act.status));
      compare_field("task_due", ptd_pkg::SLOT_W'(exp_r.task_due),
                    ptd_pkg::SLOT_W'(act.task_due));
      compare_field("task_res", exp_r.task_res, act.task_res);
      compare_field("last", ptd_pkg::SLOT_W'(exp_r.last),
                    ptd_pkg::SLOT_W'(act.last));
    endfunction
  endclass

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [ptd_pkg::OP_W-1:0]   operation = ptd_pkg::OP_TICK;
  logic [ptd_pkg::SLOT_W-1:0] slot      = '0;
  logic [ptd_pkg::TICK_W-1:0] period    = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       kind;
  logic                       status;
  logic                       task_due;
  logic [ptd_pkg::SLOT_W-1:0] task_res;
  logic                       last;

  dispatch_scoreboard sb = new;
  bit                 hold_request = 1'b0;
  int                 idle_cycles  = 0;

  periodic_task_dispatcher_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .slot      (slot),
    .period    (period),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .status    (status),
    .task_due  (task_due),
    .task_res  (task_res),
    .last      (last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{kind, status, task_due, task_res, last});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, sb.pending());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: shifting stall pattern, plus a long hold-off on request.
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        mode = (cyc / 97) % 4;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((cyc % 5) >= 2);
        endcase
      end
    end
  end

  task automatic send_item(input logic [ptd_pkg::OP_W-1:0] op,
                           input logic [ptd_pkg::SLOT_W-1:0] s,
                           input logic [ptd_pkg::TICK_W-1:0] p);
    in_valid  <= 1'b1;
    operation <= op;
    slot      <= s;
    period    <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, s, p);
    @(negedge clk);
  endtask

  function automatic logic [ptd_pkg::TICK_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 70) return ptd_pkg::TICK_W'($urandom_range(1, 12));
    if (r < 85) return ptd_pkg::TICK_W'($urandom);
    if (r < 92) return '1;
    return ptd_pkg::TICK_W'($urandom_range(13, 300));
  endfunction

  function automatic logic [ptd_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 34) return ptd_pkg::OP_TICK;
    if (r < 60) return ptd_pkg::OP_CREATE;
    if (r < 72) return ptd_pkg::OP_DELETE;
    if (r < 81) return ptd_pkg::OP_SUSPEND;
    if (r < 90) return ptd_pkg::OP_RESUME;
    return ptd_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  initial begin
    int                       counted;
    int                       burst;
    logic [ptd_pkg::OP_W-1:0] op;
    bit                       held;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    send_item(ptd_pkg::OP_TICK, 3'd0, 16'd0);
    send_item(ptd_pkg::OP_CREATE, 3'd0, 16'd1);
    send_item(ptd_pkg::OP_CREATE, 3'd7, 16'hFFFF);
    send_item(ptd_pkg::OP_CREATE, 3'd0, 16'd5);
    send_item(ptd_pkg::OP_CREATE, 3'd3, 16'd0);
    send_item(ptd_pkg::OP_CREATE, 3'd5, 16'd2);
    send_item(ptd_pkg::OP_TICK, 3'd7, 16'hFFFF);
    send_item(ptd_pkg::OP_SUSPEND, 3'd0, 16'd0);
    send_item(ptd_pkg::OP_TICK, 3'd0, 16'd0);
    send_item(ptd_pkg::OP_RESUME, 3'd0, 16'd0);
    send_item(ptd_pkg::OP_SUSPEND, 3'd6, 16'd0);
    send_item(ptd_pkg::OP_RESUME, 3'd6, 16'd0);
    send_item(ptd_pkg::OP_CREATE, 3'd6, 16'd1);
    send_item(ptd_pkg::OP_DELETE, 3'd3, 16'd0);
    send_item(ptd_pkg::OP_CREATE, 3'd3, 16'd1);
    send_item(ptd_pkg::OP_DELETE, 3'd7, 16'd0);
    send_item(ptd_pkg::OP_CREATE, 3'd7, 16'd1);
    send_item(ptd_pkg::OP_CREATE, 3'd1, 16'd1);
    send_item(ptd_pkg::OP_CREATE, 3'd2, 16'd1);
    send_item(ptd_pkg::OP_CREATE, 3'd4, 16'd1);
    send_item(ptd_pkg::OP_TICK, 3'd0, 16'd0);
    send_item(OP_SPARE_FIRST, 3'd7, 16'hFFFF);
    send_item(OP_SPARE_FIRST + 3'd1, 3'd2, 16'h5555);
    send_item(OP_SPARE_LAST, 3'd5, 16'hAAAA);
    send_item(ptd_pkg::OP_TICK, 3'd0, 16'd0);

    // Random bursts
    counted = 0;
    held = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        op = pick_op();
        send_item(op, ptd_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)), pick_period());
        counted++;
        if (!held && counted >= 120) begin
          held = 1'b1;
          hold_request = 1'b1;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks (%0d with no task due, %0d with every slot due)",
             sb.n_ticks, sb.n_idle_ticks, sb.n_full_ticks);
    $display("and %0d creates (%0d refused); %0d results checked",
             sb.n_creates, sb.n_refused, sb.n_results);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
